@@ rtl/pst_pkg.sv @@
// Shared types and constants of the passcode slot table.
package pst_pkg;

  localparam int SLOT_COUNT   = 8;
  localparam int KEY_BYTES    = 8;
  localparam int KEY_W        = 8 * KEY_BYTES;
  localparam int KEY_PORT_W   = 64;
  localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_INDEX_W = 3;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD,
    S_CLEAR,
    S_QFIRST,
    S_QSCAN,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic add;
    logic clear;
    logic scan_start;
    logic scan_step;
    logic hit_record;
    logic out_load;
  } pst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic full;
    logic hit;
    logic last;
    logic out_free;
  } pst_sts_t;

endpackage

@@ rtl/pst_if.sv @@
// Request and response channel interfaces of the passcode slot table.
interface pst_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [pst_pkg::KEY_PORT_W-1:0]  key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface pst_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              success;
  logic [pst_pkg::SLOT_INDEX_W-1:0]  slot_index;
  logic                              table_full;
  logic                              table_empty;

  modport source (output valid, output success, output slot_index, output table_full,
                  output table_empty, input ready);
  modport sink   (input valid, input success, input slot_index, input table_full,
                  input table_empty, output ready);
endinterface

@@ rtl/pst_dp.sv @@
// Datapath of the passcode slot table: valid marks, key memory, scan comparator, result register.
module pst_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        req_type,
  input  logic [pst_pkg::KEY_PORT_W-1:0]    key_value,
  input  pst_pkg::pst_cmd_t                 cmd,
  output pst_pkg::pst_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_success,
  output logic [pst_pkg::SLOT_INDEX_W-1:0]  out_slot_index,
  output logic                              out_full,
  output logic                              out_empty
);

  logic [1:0]                       req_q;
  logic [pst_pkg::KEY_W-1:0]        key_q;
  logic [pst_pkg::SLOT_COUNT-1:0]   valid;
  logic [pst_pkg::KEY_W-1:0]        key_mem [pst_pkg::SLOT_COUNT];
  logic [pst_pkg::KEY_W-1:0]        rd_key;
  logic [pst_pkg::SLOT_W-1:0]       scan_idx;
  logic [pst_pkg::SLOT_W-1:0]       rd_addr;
  logic [pst_pkg::SLOT_W-1:0]       free_idx;
  logic                             res_ok;
  logic [pst_pkg::SLOT_W-1:0]       res_idx;
  logic                             full;
  logic                             empty;

  assign full  = &valid;
  assign empty = ~|valid;

  // Lowest slot without a valid mark.
  always_comb begin
    free_idx = '0;
    for (int i = pst_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = pst_pkg::SLOT_W'(i);
      end
    end
  end

  assign rd_addr = cmd.scan_start ? '0 : pst_pkg::SLOT_W'(scan_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      key_q <= key_value[pst_pkg::KEY_W-1:0];
    end
    if (cmd.add) begin
      key_mem[free_idx] <= key_q;
    end
    if (cmd.scan_start || cmd.scan_step) begin
      rd_key   <= key_mem[rd_addr];
      scan_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clear) begin
      valid <= '0;
    end else if (cmd.add) begin
      valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok  <= 1'b0;
      res_idx <= '0;
    end else if (cmd.add) begin
      res_ok  <= 1'b1;
      res_idx <= free_idx;
    end else if (cmd.clear) begin
      res_ok  <= 1'b1;
    end else if (cmd.hit_record) begin
      res_ok  <= 1'b1;
      res_idx <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_success    <= res_ok;
      out_slot_index <= pst_pkg::SLOT_INDEX_W'(res_idx);
      out_full       <= full;
      out_empty      <= empty;
    end
  end

  assign sts.req      = pst_pkg::req_t'(req_q);
  assign sts.full     = full;
  assign sts.hit      = valid[scan_idx] && (rd_key == key_q);
  assign sts.last     = (scan_idx == pst_pkg::SLOT_W'(pst_pkg::SLOT_COUNT - 1));
  assign sts.out_free = !out_valid || out_ready;

  a_clear_empties: assert property (@(posedge clk) (!rst && cmd.clear) |=> (valid == '0))
    else $error("valid marks remain after a clear");
  a_add_one_more: assert property (@(posedge clk) (!rst && cmd.add && !cmd.clear)
    |=> ($countones(valid) == $past($countones(valid)) + 1))
    else $error("add did not set exactly one new valid mark");
  a_marks_hold: assert property (@(posedge clk) (!rst && !cmd.add && !cmd.clear)
    |=> $stable(valid))
    else $error("valid marks changed without add or clear");
  a_scan_in_range: assert property (@(posedge clk) (!rst && cmd.scan_step)
    |-> (scan_idx != pst_pkg::SLOT_W'(pst_pkg::SLOT_COUNT - 1)))
    else $error("scan stepped past the last slot");
  a_no_overwrite: assert property (@(posedge clk) (!rst && cmd.out_load) |-> sts.out_free)
    else $error("result loaded over an untaken result");

endmodule

@@ rtl/pst_ctrl.sv @@
// Controller state machine of the passcode slot table.
module pst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pst_pkg::pst_sts_t  sts,
  output pst_pkg::pst_cmd_t  cmd
);

  pst_pkg::state_t state;
  pst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      pst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pst_pkg::S_DISPATCH;
        end
      end
      pst_pkg::S_DISPATCH: begin
        case (sts.req)
          pst_pkg::REQ_ADD:   state_next = pst_pkg::S_ADD;
          pst_pkg::REQ_QUERY: state_next = pst_pkg::S_QFIRST;
          pst_pkg::REQ_CLEAR: state_next = pst_pkg::S_CLEAR;
          default:            state_next = pst_pkg::S_RESULT;
        endcase
      end
      pst_pkg::S_ADD: begin
        cmd.add    = !sts.full;
        state_next = pst_pkg::S_RESULT;
      end
      pst_pkg::S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = pst_pkg::S_RESULT;
      end
      pst_pkg::S_QFIRST: begin
        cmd.scan_start = 1'b1;
        state_next     = pst_pkg::S_QSCAN;
      end
      pst_pkg::S_QSCAN: begin
        if (sts.hit) begin
          cmd.hit_record = 1'b1;
          state_next     = pst_pkg::S_RESULT;
        end else if (sts.last) begin
          state_next = pst_pkg::S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      pst_pkg::S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pst_pkg::S_IDLE;
        end
      end
      default: state_next = pst_pkg::S_IDLE;
    endcase
  end

  a_ready_idle_only: assert property (@(posedge clk) (!rst && in_ready && in_valid)
    |=> (state == pst_pkg::S_DISPATCH))
    else $error("accepted transaction did not move to dispatch");
  a_scan_follows_start: assert property (@(posedge clk) (!rst && cmd.scan_start)
    |=> (state == pst_pkg::S_QSCAN))
    else $error("scan start not followed by scan");
  a_one_update: assert property (@(posedge clk)
    !rst |-> $countones({cmd.add, cmd.clear, cmd.hit_record, cmd.load}) <= 1)
    else $error("conflicting datapath commands");

endmodule

@@ rtl/passcode_slot_table.sv @@
// Top level of the passcode slot table: controller and datapath joined by command and status.
//
// The block keeps eight passcode slots, each a valid mark and a 64-bit key.
// Requests arrive on the req channel (req_type, key_value); each accepted
// transaction yields exactly one response transaction on the rsp channel
// (success, slot_index, table_full, table_empty). Both channels move a
// transaction when valid and ready are high at a rising clock edge.
// Requests are handled one at a time: req.ready is high only while the
// controller is idle. After acceptance, add and clear pass through the
// dispatch state, their own state and the result state, where the response
// is loaded; an unused request code passes through dispatch and result only.
// A query scans the key memory through one comparator, one slot per cycle
// after a read start state, until the first match or the last slot. The next
// request can be accepted in the cycle after the response is loaded.
// The response sits in an output register; if the receiver stalls, the
// block still accepts and processes the next request and waits only when
// that next response is ready to be loaded.
// A synchronous active-high rst clears all valid marks, the controller and
// the response valid flag; stored keys are not cleared, and a stored key
// counts in a query only while the valid mark of its slot is set.
module passcode_slot_table (
  input  logic      clk,
  input  logic      rst,
  pst_req_if.sink   req,
  pst_rsp_if.source rsp
);

  pst_pkg::pst_cmd_t cmd;
  pst_pkg::pst_sts_t sts;
  logic              ctrl_ready;

  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ctrl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pst_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req.req_type),
    .key_value      (req.key_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_success    (rsp.success),
    .out_slot_index (rsp.slot_index),
    .out_full       (rsp.table_full),
    .out_empty      (rsp.table_empty)
  );

  // The request channel is ready exactly when the controller is idle.
  assign req.ready = ctrl_ready;

endmodule

@@ tb/passcode_slot_table_checker.sv @@
// Checker that predicts passcode slot table responses and compares them field by field.
`timescale 1ns / 1ps
module passcode_slot_table_checker (
  input  logic clk,
  input  logic rst,
  pst_req_if   req,
  pst_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic                             success;
    logic [pst_pkg::SLOT_INDEX_W-1:0] slot_index;
    logic                             table_full;
    logic                             table_empty;
  } slot_reply_t;

  logic [pst_pkg::SLOT_COUNT-1:0] slot_used;
  logic [pst_pkg::KEY_W-1:0]      slot_keys [pst_pkg::SLOT_COUNT];
  slot_reply_t                    awaited_replies [$];
  int                             reply_count;

  // Applies one request to the shadow table and returns the response it should produce.
  function automatic slot_reply_t apply_request(logic [1:0] kind,
                                                logic [pst_pkg::KEY_PORT_W-1:0] key_in);
    slot_reply_t               reply;
    logic [pst_pkg::KEY_W-1:0] key;
    key   = key_in[pst_pkg::KEY_W-1:0];
    reply = '0;
    case (kind)
      pst_pkg::REQ_ADD: begin
        for (int i = 0; i < pst_pkg::SLOT_COUNT; i++) begin
          if (!reply.success && !slot_used[i]) begin
            slot_used[i]     = 1'b1;
            slot_keys[i]     = key;
            reply.success    = 1'b1;
            reply.slot_index = i[pst_pkg::SLOT_INDEX_W-1:0];
          end
        end
      end
      pst_pkg::REQ_QUERY: begin
        for (int i = 0; i < pst_pkg::SLOT_COUNT; i++) begin
          if (!reply.success && slot_used[i] && slot_keys[i] == key) begin
            reply.success    = 1'b1;
            reply.slot_index = i[pst_pkg::SLOT_INDEX_W-1:0];
          end
        end
      end
      pst_pkg::REQ_CLEAR: begin
        slot_used     = '0;
        reply.success = 1'b1;
      end
      default: ;
    endcase
    reply.table_full  = &slot_used;
    reply.table_empty = ~|slot_used;
    return reply;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] response %0d: %s", $realtime, reply_count, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    slot_reply_t want;
    if (rst) begin
      slot_used = '0;
      awaited_replies.delete();
      fail_count  = 0;
      reply_count = 0;
      outstanding <= 0;
    end else begin
      // Responses are handled first: a response accepted together with a new
      // request always belongs to an older request.
      if (rsp.valid && rsp.ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("response arrived with no request waiting");
        end else begin
          want = awaited_replies.pop_front();
          compare_field("success", 8'(want.success), 8'(rsp.success));
          compare_field("slot_index", 8'(want.slot_index), 8'(rsp.slot_index));
          compare_field("table_full", 8'(want.table_full), 8'(rsp.table_full));
          compare_field("table_empty", 8'(want.table_empty), 8'(rsp.table_empty));
        end
        reply_count++;
      end
      if (req.valid && req.ready)
        awaited_replies.push_back(apply_request(req.req_type, req.key_value));
      outstanding <= awaited_replies.size();
    end
  end

endmodule

@@ tb/passcode_slot_table_test.sv @@
// Top of the passcode slot table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module passcode_slot_table_test;

  // Request code 3 has no meaning in the block; it must leave the table alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS    = 1250;
  localparam int MAX_IDLE           = 18;
  localparam int POOL_DEPTH         = 24;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;

  pst_req_if req_ch ();
  pst_rsp_if rsp_ch ();

  passcode_slot_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  passcode_slot_table_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // When set, the side concerned runs back to back with no idle cycles.
  bit                             sender_calm;
  bit                             receiver_calm;
  logic [pst_pkg::KEY_PORT_W-1:0] key_pool [$];

  // Presents one request after a random idle gap (none while sender_calm is set)
  // and holds it until the block takes the transaction. The valid stays high
  // across back-to-back requests, so only one nonblocking write lands on it per edge.
  task automatic send_request(logic [1:0] kind, logic [pst_pkg::KEY_PORT_W-1:0] key);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.key_value <= key;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == pst_pkg::REQ_ADD) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH)
        void'(key_pool.pop_front());
    end
  endtask

  // Drops valid and waits until every response in flight has been taken.
  // At least one edge always passes, so valid never sees two writes at once.
  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [pst_pkg::KEY_PORT_W-1:0] fresh_key();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      return '0;
    else if (pick == 1)
      return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Keys for random traffic. Queries mostly reuse recently added keys so
  // that hits, lowest-of-several hits and single-bit near misses are common.
  function automatic logic [pst_pkg::KEY_PORT_W-1:0] pick_key(logic [1:0] kind);
    int                             roll;
    logic [pst_pkg::KEY_PORT_W-1:0] base;
    roll = $urandom_range(0, 99);
    if (key_pool.size() == 0 || kind == pst_pkg::REQ_CLEAR || kind == REQ_UNUSED)
      return fresh_key();
    base = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (kind == pst_pkg::REQ_ADD)
      return (roll < 25) ? base : fresh_key();
    if (roll < 65)
      return base;
    if (roll < 80)
      return base ^ (64'd1 << $urandom_range(0, pst_pkg::KEY_PORT_W - 1));
    return fresh_key();
  endfunction

  // Receiver: for each response it stalls a drawn number of cycles, then
  // holds ready high until the response transaction completes.
  initial begin
    int stall;
    int taken;
    receiver_calm = 1'b0;
    taken = 0;
    forever begin
      if (taken % 40 == 0)
        receiver_calm = ($urandom_range(0, 3) == 0);
      stall = receiver_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      taken++;
    end
  end

  // Sender and verdict.
  initial begin
    logic [1:0] kind;
    int         roll;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= pst_pkg::REQ_ADD;
    req_ch.key_value <= '0;
    sender_calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A query on the empty table misses, then the table is
    // filled with the extreme keys, a duplicate and random keys.
    send_request(pst_pkg::REQ_QUERY, '0);
    send_request(pst_pkg::REQ_ADD, '1);
    send_request(pst_pkg::REQ_ADD, '0);
    send_request(pst_pkg::REQ_ADD, '1);
    // Two slots hold all ones: the lower one must be reported.
    send_request(pst_pkg::REQ_QUERY, '1);
    send_request(pst_pkg::REQ_QUERY, '0);
    send_request(pst_pkg::REQ_ADD, 64'h5555_5555_5555_5555);
    send_request(pst_pkg::REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(pst_pkg::REQ_ADD, fresh_key());
    send_request(pst_pkg::REQ_ADD, fresh_key());
    send_request(pst_pkg::REQ_ADD, 64'h8000_0000_0000_0001);
    // Table is now full: another add must fail and change nothing.
    send_request(pst_pkg::REQ_ADD, 64'h0123_4567_89AB_CDEF);
    send_request(pst_pkg::REQ_QUERY, 64'h0123_4567_89AB_CDEF);
    send_request(pst_pkg::REQ_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(pst_pkg::REQ_QUERY, 64'h8000_0000_0000_0001);
    send_request(REQ_UNUSED, '1);
    // Clear carries a nonzero key, which must be ignored.
    send_request(pst_pkg::REQ_CLEAR, '1);
    send_request(pst_pkg::REQ_CLEAR, '0);
    send_request(REQ_UNUSED, '0);
    // Keys stay in the slots after a clear but must no longer match.
    send_request(pst_pkg::REQ_QUERY, '1);
    send_request(pst_pkg::REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(pst_pkg::REQ_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(pst_pkg::REQ_QUERY, 64'h5555_5555_5555_5555);

    // Let the block empty completely before the random traffic starts.
    drain_requests();

    // Random part. Clears are rare enough that the table fills up often,
    // so failing adds and full-table queries are well exercised.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0)
        sender_calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_REQUESTS / 2 || $urandom_range(0, 99) == 0)
        drain_requests();
      roll = $urandom_range(0, 99);
      if (roll < 4)
        kind = pst_pkg::REQ_CLEAR;
      else if (roll < 6)
        kind = REQ_UNUSED;
      else if (roll < 46)
        kind = pst_pkg::REQ_ADD;
      else
        kind = pst_pkg::REQ_QUERY;
      send_request(kind, pick_key(kind));
    end

    drain_requests();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("passcode_slot_table test passed");
    else
      $display("passcode_slot_table test failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of every request.
  initial begin
    #5_000_000;
    $display("passcode_slot_table test failed");
    $finish;
  end

endmodule
